### rtl/mlse_pkg.sv
`timescale 1ns / 1ps
package mlse_pkg;

    localparam int SLOTS    = 10;
    localparam int SLOT_CAP = 6;
    localparam int WORDS    = SLOTS * SLOT_CAP;
    localparam int AW       = $clog2(WORDS);
    localparam int KW       = 32 + AW;

    localparam logic [3:0] CMD_CREATE    = 4'd0;
    localparam logic [3:0] CMD_APPEND    = 4'd1;
    localparam logic [3:0] CMD_DEL_LAST  = 4'd2;
    localparam logic [3:0] CMD_DEL_VALUE = 4'd3;
    localparam logic [3:0] CMD_READ      = 4'd4;
    localparam logic [3:0] CMD_READ_SORT = 4'd5;
    localparam logic [3:0] CMD_READ_ALL  = 4'd6;
    localparam logic [3:0] CMD_ALL_SORT  = 4'd7;
    localparam logic [3:0] CMD_GROW      = 4'd8;
    localparam logic [3:0] CMD_COUNT     = 4'd9;
    localparam logic [3:0] CMD_RELEASE   = 4'd10;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BADPOS    = 4'd1;
    localparam logic [3:0] ST_BADSIZE   = 4'd2;
    localparam logic [3:0] ST_EXISTS    = 4'd3;
    localparam logic [3:0] ST_NOMEM     = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_NOLIST    = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_NOTFOUND  = 4'd8;
    localparam logic [3:0] ST_ALLEMPTY  = 4'd9;

    typedef struct packed {
        logic [3:0]         op;
        logic               slot_ok;
        logic               all_lists;
        logic               sorted;
        logic [3:0]         slot;
        logic signed [31:0] value;
        logic [5:0]         size;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [31:0] data_word;
        logic               has_data;
        logic [2:0]         element_count;
        logic               last;
    } res_t;

    function automatic logic [AW-1:0] slot_base(input logic [3:0] s);
        logic [AW+3:0] prod;
        begin
            prod = {{AW{1'b0}}, s} * (AW + 4)'(SLOT_CAP);
            return prod[AW-1:0];
        end
    endfunction

endpackage

### rtl/mlse_front.sv
`timescale 1ns / 1ps
module mlse_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         cmd,
    input  logic [3:0]         slot,
    input  logic signed [31:0] value,
    input  logic [5:0]         size,
    output logic               cq_avail,
    input  logic               cq_pop,
    output mlse_pkg::cmd_t     cq_cmd
);
    import mlse_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       store;

    always_comb
    begin
        dec.op        = cmd;
        dec.slot_ok   = (slot < 4'(SLOTS));
        dec.all_lists = (cmd == CMD_READ_ALL) || (cmd == CMD_ALL_SORT);
        dec.sorted    = (cmd == CMD_READ_SORT) || (cmd == CMD_ALL_SORT);
        dec.slot      = slot;
        dec.value     = value;
        dec.size      = size;
    end

    assign full     = (cnt_reg == 2'd2);
    assign cq_avail = (cnt_reg != 2'd0);
    assign cq_cmd   = q_reg[rd_ptr_reg];
    // drop unused codes at the door: they give no result
    assign store    = push && !full && (cmd <= CMD_RELEASE);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (store)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cq_pop && cq_avail)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (store && !(cq_pop && cq_avail))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!store && cq_pop && cq_avail)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

### rtl/mlse_resq.sv
`timescale 1ns / 1ps
module mlse_resq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rq_push,
    input  mlse_pkg::res_t rq_data,
    output logic           rq_full,
    output logic           empty,
    input  logic           pop,
    output mlse_pkg::res_t head
);
    import mlse_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign rq_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign head    = q_reg[rd_ptr_reg];
    assign do_push = rq_push && !rq_full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= rq_data;
        end
    end

endmodule

### rtl/mlse_back.sv
`timescale 1ns / 1ps
module mlse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cq_avail,
    output logic           cq_pop,
    input  mlse_pkg::cmd_t cq_cmd,
    output logic           rq_push,
    output mlse_pkg::res_t rq_data,
    input  logic           rq_full
);
    import mlse_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_EMIT  = 4'd2;
    localparam logic [3:0] S_FD_RD = 4'd3;
    localparam logic [3:0] S_FD_EV = 4'd4;
    localparam logic [3:0] S_SH_RD = 4'd5;
    localparam logic [3:0] S_SH_WR = 4'd6;
    localparam logic [3:0] S_SC_GO = 4'd7;
    localparam logic [3:0] S_SC_RD = 4'd8;
    localparam logic [3:0] S_SC_EV = 4'd9;

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    ret_reg, ret_next;
    cmd_t          c_reg, c_next;
    res_t          res_reg, res_next;
    logic [2:0]    cap_reg [SLOTS];
    logic [2:0]    cnt_reg [SLOTS];
    logic [2:0]    cap_next [SLOTS];
    logic [2:0]    cnt_next [SLOTS];
    logic [2:0]    j_reg, j_next;
    logic [3:0]    sc_slot_reg, sc_slot_next;
    logic [2:0]    sc_j_reg, sc_j_next;
    logic          inc_reg, inc_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] total_reg, total_next;
    logic [AW-1:0] emitted_reg, emitted_next;
    logic          first_reg, first_next;
    logic          have_last_reg, have_last_next;
    logic [KW-1:0] last_key_reg, last_key_next;
    logic          best_ok_reg, best_ok_next;
    logic [KW-1:0] best_key_reg, best_key_next;
    logic [31:0]   best_val_reg, best_val_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;
    logic [3:0]    idx;
    logic [2:0]    cur_cap, cur_cnt;
    logic [AW-1:0] base;
    logic [6:0]    grow_sum;
    logic [KW-1:0] key;
    logic          take;
    logic [3:0]    hi_slot;
    logic          pass_end;
    logic [AW-1:0] total_fin;
    logic          is_last;

    assign idx      = (state_reg == S_SC_RD) ? sc_slot_reg : c_reg.slot;
    assign cur_cap  = cap_reg[idx];
    assign cur_cnt  = cnt_reg[idx];
    assign base     = slot_base(c_reg.slot);
    assign grow_sum = {4'd0, cur_cap} + {1'b0, c_reg.size};
    assign hi_slot  = c_reg.all_lists ? 4'(SLOTS - 1) : c_reg.slot;
    assign key      = c_reg.sorted ? {rd_data_reg ^ 32'h8000_0000, pos_reg}
                                   : {32'd0, pos_reg};

    assign cq_pop  = (state_reg == S_IDLE) && cq_avail;
    assign rq_push = (state_reg == S_EMIT) && !rq_full;
    assign rq_data = res_reg;

    always_comb
    begin
        raddr = base + AW'(j_reg);
        case (state_reg)
            S_SH_RD: raddr = base + AW'(j_reg) + AW'(1);
            S_SC_RD: raddr = slot_base(sc_slot_reg) + AW'(sc_j_reg);
            default: raddr = base + AW'(j_reg);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        c_next         = c_reg;
        res_next       = res_reg;
        cap_next       = cap_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        sc_slot_next   = sc_slot_reg;
        sc_j_next      = sc_j_reg;
        inc_next       = inc_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        emitted_next   = emitted_reg;
        first_next     = first_reg;
        have_last_next = have_last_reg;
        last_key_next  = last_key_reg;
        best_ok_next   = best_ok_reg;
        best_key_next  = best_key_reg;
        best_val_next  = best_val_reg;
        we             = 1'b0;
        waddr          = base + AW'(cur_cnt);
        wdata          = c_reg.value;
        take           = 1'b0;
        pass_end       = 1'b0;
        total_fin      = total_reg;
        is_last        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cq_avail)
                begin
                    c_next     = cq_cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next.status        = ST_OK;
                res_next.data_word     = '0;
                res_next.has_data      = 1'b0;
                res_next.element_count = '0;
                res_next.last          = 1'b1;
                ret_next               = S_IDLE;
                state_next             = S_EMIT;
                if (c_reg.op == CMD_RELEASE)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        cap_next[i] = '0;
                        cnt_next[i] = '0;
                    end
                end
                else if (c_reg.all_lists)
                begin
                    state_next = S_SC_GO;
                end
                else if (!c_reg.slot_ok)
                begin
                    res_next.status = ST_BADPOS;
                end
                else if (c_reg.op == CMD_CREATE)
                begin
                    if (c_reg.size == 6'd0)
                        res_next.status = ST_BADSIZE;
                    else if (cur_cap != 3'd0)
                        res_next.status = ST_EXISTS;
                    else if (c_reg.size > 6'(SLOT_CAP))
                        res_next.status = ST_NOMEM;
                    else
                    begin
                        cap_next[c_reg.slot] = c_reg.size[2:0];
                        cnt_next[c_reg.slot] = '0;
                    end
                end
                else if (cur_cap == 3'd0)
                begin
                    res_next.status = ST_NOLIST;
                end
                else
                begin
                    case (c_reg.op)
                        CMD_APPEND:
                        begin
                            if (cur_cnt >= cur_cap)
                                res_next.status = ST_FULL;
                            else
                            begin
                                we                   = 1'b1;
                                cnt_next[c_reg.slot] = cur_cnt + 3'd1;
                            end
                        end
                        CMD_DEL_LAST:
                        begin
                            if (cur_cnt == 3'd0)
                                res_next.status = ST_EMPTY;
                            else
                                cnt_next[c_reg.slot] = cur_cnt - 3'd1;
                        end
                        CMD_DEL_VALUE:
                        begin
                            if (cur_cnt == 3'd0)
                                res_next.status = ST_EMPTY;
                            else
                            begin
                                j_next     = '0;
                                state_next = S_FD_RD;
                            end
                        end
                        CMD_READ, CMD_READ_SORT:
                        begin
                            state_next = S_SC_GO;
                        end
                        CMD_GROW:
                        begin
                            if (grow_sum > 7'(SLOT_CAP))
                                res_next.status = ST_NOMEM;
                            else
                            begin
                                cap_next[c_reg.slot] = grow_sum[2:0];
                                if ({4'd0, cur_cnt} > grow_sum)
                                    cnt_next[c_reg.slot] = grow_sum[2:0];
                            end
                        end
                        CMD_COUNT:
                        begin
                            if (cur_cnt == 3'd0)
                                res_next.status = ST_EMPTY;
                            else
                                res_next.element_count = cur_cnt;
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
                if (state_next == S_SC_GO)
                begin
                    first_next     = 1'b1;
                    total_next     = '0;
                    emitted_next   = '0;
                    have_last_next = 1'b0;
                end
            end

            S_EMIT:
            begin
                if (!rq_full)
                begin
                    state_next = ret_reg;
                end
            end

            S_FD_RD:
            begin
                state_next = S_FD_EV;
            end

            S_FD_EV:
            begin
                if (rd_data_reg == c_reg.value)
                begin
                    if (j_reg + 3'd1 < cur_cnt)
                        state_next = S_SH_RD;
                    else
                    begin
                        cnt_next[c_reg.slot] = cur_cnt - 3'd1;
                        state_next           = S_EMIT;
                    end
                end
                else if (j_reg + 3'd1 == cur_cnt)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_FD_RD;
                end
            end

            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                // move the following word down one place
                we     = 1'b1;
                waddr  = base + AW'(j_reg);
                wdata  = rd_data_reg;
                j_next = j_reg + 3'd1;
                if (j_reg + 3'd2 < cur_cnt)
                    state_next = S_SH_RD;
                else
                begin
                    cnt_next[c_reg.slot] = cur_cnt - 3'd1;
                    state_next           = S_EMIT;
                end
            end

            S_SC_GO:
            begin
                sc_slot_next = c_reg.all_lists ? 4'd0 : c_reg.slot;
                sc_j_next    = '0;
                best_ok_next = 1'b0;
                state_next   = S_SC_RD;
            end

            S_SC_RD:
            begin
                inc_next   = (cur_cap != 3'd0) && (sc_j_reg < cur_cnt);
                pos_next   = raddr;
                state_next = S_SC_EV;
            end

            S_SC_EV:
            begin
                // keep the smallest key above the one sent last
                if (inc_reg)
                begin
                    if (first_reg)
                        total_next = total_reg + AW'(1);
                    take = (!have_last_reg || key > last_key_reg)
                        && (!best_ok_reg || key < best_key_reg);
                    if (take)
                    begin
                        best_ok_next  = 1'b1;
                        best_key_next = key;
                        best_val_next = rd_data_reg;
                    end
                end
                pass_end = (sc_j_reg == 3'(SLOT_CAP - 1)) && (sc_slot_reg == hi_slot);
                if (sc_j_reg == 3'(SLOT_CAP - 1))
                begin
                    sc_j_next    = '0;
                    sc_slot_next = sc_slot_reg + 4'd1;
                end
                else
                begin
                    sc_j_next = sc_j_reg + 3'd1;
                end
                if (!pass_end)
                begin
                    state_next = S_SC_RD;
                end
                else
                begin
                    total_fin  = first_reg ? total_next : total_reg;
                    first_next = 1'b0;
                    res_next.status        = ST_OK;
                    res_next.element_count = '0;
                    state_next             = S_EMIT;
                    if (total_fin == '0)
                    begin
                        res_next.status    = c_reg.all_lists ? ST_ALLEMPTY : ST_OK;
                        res_next.data_word = '0;
                        res_next.has_data  = 1'b0;
                        res_next.last      = 1'b1;
                        ret_next           = S_IDLE;
                    end
                    else
                    begin
                        is_last            = (emitted_reg + AW'(1) == total_fin);
                        res_next.data_word = best_val_next;
                        res_next.has_data  = 1'b1;
                        res_next.last      = is_last;
                        emitted_next       = emitted_reg + AW'(1);
                        have_last_next     = 1'b1;
                        last_key_next      = best_key_next;
                        ret_next           = is_last ? S_IDLE : S_SC_GO;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            first_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            best_ok_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                cap_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            first_reg     <= first_next;
            have_last_reg <= have_last_next;
            best_ok_reg   <= best_ok_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        res_reg      <= res_next;
        j_reg        <= j_next;
        sc_slot_reg  <= sc_slot_next;
        sc_j_reg     <= sc_j_next;
        inc_reg      <= inc_next;
        pos_reg      <= pos_next;
        total_reg    <= total_next;
        emitted_reg  <= emitted_next;
        last_key_reg <= last_key_next;
        best_key_reg <= best_key_next;
        best_val_reg <= best_val_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

endmodule

### rtl/multi_list_store_engine_unit.sv
`timescale 1ns / 1ps
// Bank of ten bounded lists of signed words, driven by commands.
// Command channel: drive cmd/slot/value/size with push; a transfer happens on a
// rising edge with push high and full low. Unused command codes are taken and dropped.
// Result channel: while empty is low the oldest result sits on status, data_word,
// has_data, element_count and last; an edge with pop high and empty low transfers it.
// A two-entry command queue feeds the execution engine, and a two-entry result
// queue follows it, so commands keep arriving while a result waits to be popped.
// Simple commands pass through the IDLE, EXEC and EMIT states to the result queue.
// Delete by value reads and checks each word searched (FD_RD, FD_EV), then reads
// and writes each word moved down (SH_RD, SH_WR). Reads run one pass per result
// over the words in range, one list or the whole bank, each pass from SC_GO to EMIT,
// plus one pass when the list is empty; every pass reads each slot position of the
// single word store port once, reading (SC_RD) and weighing (SC_EV) each word in turn.
// Reset clears all capacities and counts: no list exists afterwards. The word store
// is not cleared; only words an append wrote, or a delete moved down, are ever used.
// When pop stays low the result queue fills, the engine holds, and full rises
// once the command queue is full too.
module multi_list_store_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         cmd,
    input  logic [3:0]         slot,
    input  logic signed [31:0] value,
    input  logic [5:0]         size,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         status,
    output logic signed [31:0] data_word,
    output logic               has_data,
    output logic [2:0]         element_count,
    output logic               last
);
    import mlse_pkg::*;

    logic cq_avail, cq_pop;
    cmd_t cq_cmd;
    logic rq_push, rq_full;
    res_t rq_data;
    res_t head;

    mlse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .slot     (slot),
        .value    (value),
        .size     (size),
        .cq_avail (cq_avail),
        .cq_pop   (cq_pop),
        .cq_cmd   (cq_cmd)
    );

    mlse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_avail (cq_avail),
        .cq_pop   (cq_pop),
        .cq_cmd   (cq_cmd),
        .rq_push  (rq_push),
        .rq_data  (rq_data),
        .rq_full  (rq_full)
    );

    mlse_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .rq_push (rq_push),
        .rq_data (rq_data),
        .rq_full (rq_full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign status        = head.status;
    assign data_word     = head.data_word;
    assign has_data      = head.has_data;
    assign element_count = head.element_count;
    assign last          = head.last;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import mlse_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [3:0]         cmd;
    logic [3:0]         slot;
    logic signed [31:0] value;
    logic [5:0]         size;
    logic               empty;
    logic               pop;
    logic [3:0]         status;
    logic signed [31:0] data_word;
    logic               has_data;
    logic [2:0]         element_count;
    logic               last;

    multi_list_store_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd), .slot(slot),
        .value(value), .size(size), .empty(empty), .pop(pop), .status(status),
        .data_word(data_word), .has_data(has_data), .element_count(element_count),
        .last(last)
    );

    // shadow copy of the list bank
    int                 shadow_cap [SLOTS];
    int                 shadow_cnt [SLOTS];
    logic signed [31:0] shadow_words [WORDS];

    res_t pending_results [$];
    int   mismatches;
    int   cmds_sent;
    int   results_seen;
    int   reads_seen;
    bit   quiet;
    int   pop_hold;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic add_result(input logic [3:0] st, input logic signed [31:0] w,
                              input logic hd, input logic [2:0] ec, input logic lst);
        res_t r;
        r.status        = st;
        r.data_word     = w;
        r.has_data      = hd;
        r.element_count = ec;
        r.last          = lst;
        pending_results.push_back(r);
    endtask

    task automatic list_words(ref logic signed [31:0] buf_w [WORDS], input int n,
                              input bit sorted);
        logic signed [31:0] x;
        int j;
        if (sorted)
        begin
            for (int i = 1; i < n; i++)
            begin
                x = buf_w[i];
                j = i - 1;
                while (j >= 0 && buf_w[j] > x)
                begin
                    buf_w[j + 1] = buf_w[j];
                    j--;
                end
                buf_w[j + 1] = x;
            end
        end
        if (n == 0)
            add_result(ST_OK, 0, 1'b0, 3'd0, 1'b1);
        for (int i = 0; i < n; i++)
            add_result(ST_OK, buf_w[i], 1'b1, 3'd0, i == n - 1);
    endtask

    task automatic predict_command(input logic [3:0] c, input logic [3:0] s,
                                   input logic signed [31:0] v, input logic [5:0] sz);
        logic signed [31:0] buf_w [WORDS];
        logic [3:0] st;
        int n;
        int b;
        int cp;
        int cn;
        logic [2:0] ec;
        n  = 0;
        st = ST_OK;
        ec = 3'd0;
        if (c > CMD_RELEASE)
            return;
        if (c == CMD_RELEASE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_cap[i] = 0;
                shadow_cnt[i] = 0;
            end
            add_result(ST_OK, 0, 1'b0, 3'd0, 1'b1);
            return;
        end
        if (c == CMD_READ_ALL || c == CMD_ALL_SORT)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (shadow_cap[i] != 0)
                    for (int j = 0; j < shadow_cnt[i]; j++)
                        buf_w[n++] = shadow_words[i * SLOT_CAP + j];
            if (n == 0)
                add_result(ST_ALLEMPTY, 0, 1'b0, 3'd0, 1'b1);
            else
                list_words(buf_w, n, c == CMD_ALL_SORT);
            return;
        end
        if (s >= SLOTS)
        begin
            add_result(ST_BADPOS, 0, 1'b0, 3'd0, 1'b1);
            return;
        end
        b  = s * SLOT_CAP;
        cp = shadow_cap[s];
        cn = shadow_cnt[s];
        if (c == CMD_CREATE)
        begin
            if (sz == 0)
                st = ST_BADSIZE;
            else if (cp != 0)
                st = ST_EXISTS;
            else if (sz > SLOT_CAP)
                st = ST_NOMEM;
            else
            begin
                shadow_cap[s] = sz;
                shadow_cnt[s] = 0;
            end
            add_result(st, 0, 1'b0, 3'd0, 1'b1);
            return;
        end
        if (cp == 0)
        begin
            add_result(ST_NOLIST, 0, 1'b0, 3'd0, 1'b1);
            return;
        end
        case (c)
            CMD_APPEND:
                if (cn >= cp)
                    st = ST_FULL;
                else
                begin
                    shadow_words[b + cn] = v;
                    shadow_cnt[s] = cn + 1;
                end
            CMD_DEL_LAST:
                if (cn == 0)
                    st = ST_EMPTY;
                else
                    shadow_cnt[s] = cn - 1;
            CMD_DEL_VALUE:
                if (cn == 0)
                    st = ST_EMPTY;
                else
                begin
                    st = ST_NOTFOUND;
                    for (int i = 0; i < cn; i++)
                        if (st == ST_NOTFOUND && shadow_words[b + i] == v)
                        begin
                            // shift later words down over the match
                            for (int j = i; j + 1 < cn; j++)
                                shadow_words[b + j] = shadow_words[b + j + 1];
                            shadow_cnt[s] = cn - 1;
                            st = ST_OK;
                        end
                end
            CMD_READ, CMD_READ_SORT:
            begin
                for (int j = 0; j < cn; j++)
                    buf_w[n++] = shadow_words[b + j];
                list_words(buf_w, n, c == CMD_READ_SORT);
                return;
            end
            CMD_GROW:
                if (cp + sz > SLOT_CAP)
                    st = ST_NOMEM;
                else
                    shadow_cap[s] = cp + sz;
            default:
                if (cn == 0)
                    st = ST_EMPTY;
                else
                    ec = 3'(cn);
        endcase
        add_result(st, 0, 1'b0, ec, 1'b1);
    endtask

    // push stays high across back-to-back transfers unless a random gap lowers it; the caller lowers it to idle
    task automatic send_command(input logic [3:0] c, input logic [3:0] s,
                                input logic signed [31:0] v, input logic [5:0] sz);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        cmd   <= c;
        slot  <= s;
        value <= v;
        size  <= sz;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_command(c, s, v, sz);
        cmds_sent++;
    endtask

    always @(posedge clk)
    begin
        if (pop_hold > 0 && !quiet)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else if (!quiet && $urandom_range(0, 12) == 0)
        begin
            pop <= 1'b0;
            pop_hold = $urandom_range(0, 18);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (has_data)
                reads_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d data %0d", status, data_word);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || data_word !== want.data_word ||
                    has_data !== want.has_data || element_count !== want.element_count ||
                    last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 want.status, want.data_word, want.has_data,
                                 want.element_count, want.last, status, data_word,
                                 has_data, element_count, last);
                end
            end
        end
    end

    task automatic test_create_checks();
        send_command(CMD_CREATE, 4'd15, 0, 6'd1);
        send_command(CMD_CREATE, 4'd0, 0, 6'd0);
        send_command(CMD_CREATE, 4'd0, 0, 6'd63);
        send_command(CMD_CREATE, 4'd0, 0, 6'd6);
        send_command(CMD_CREATE, 4'd0, 0, 6'd1);
        send_command(CMD_READ, 4'd0, 0, 6'd0);
        send_command(CMD_READ_ALL, 4'd0, 0, 6'd0);
    endtask

    task automatic test_list_edits();
        send_command(CMD_APPEND, 4'd0, 32'sh8000_0000, 6'd0);
        send_command(CMD_APPEND, 4'd0, 32'sh7fff_ffff, 6'd0);
        send_command(CMD_APPEND, 4'd0, -32'sd1, 6'd0);
        send_command(CMD_APPEND, 4'd0, 0, 6'd0);
        send_command(CMD_APPEND, 4'd3, 5, 6'd0);
        send_command(CMD_READ_SORT, 4'd0, 0, 6'd0);
        send_command(CMD_DEL_VALUE, 4'd0, 5, 6'd0);
        send_command(CMD_DEL_VALUE, 4'd0, -32'sd1, 6'd0);
        send_command(CMD_DEL_LAST, 4'd0, 0, 6'd0);
        send_command(CMD_COUNT, 4'd0, 0, 6'd0);
    endtask

    task automatic test_grow_and_limits();
        send_command(CMD_GROW, 4'd0, 0, 6'd0);
        send_command(CMD_GROW, 4'd0, 0, 6'd63);
        send_command(CMD_CREATE, 4'd1, 0, 6'd1);
        send_command(CMD_APPEND, 4'd1, 9, 6'd0);
        send_command(CMD_APPEND, 4'd1, 9, 6'd0);
        send_command(CMD_DEL_LAST, 4'd1, 0, 6'd0);
        send_command(CMD_DEL_LAST, 4'd1, 0, 6'd0);
        send_command(CMD_DEL_VALUE, 4'd1, 9, 6'd0);
        send_command(CMD_COUNT, 4'd1, 0, 6'd0);
        send_command(CMD_GROW, 4'd1, 0, 6'd5);
        send_command(CMD_ALL_SORT, 4'd0, 0, 6'd0);
    endtask

    task automatic test_release_and_unused();
        send_command(CMD_RELEASE, 4'd0, 0, 6'd0);
        send_command(4'd11, 4'd0, 0, 6'd0);
        send_command(4'd15, 4'hf, -32'sd1, 6'd63);
        send_command(CMD_READ, 4'd0, 0, 6'd0);
    endtask

    task automatic test_random_traffic(input int n_cmds);
        int pick;
        logic [3:0] c;
        logic [3:0] s;
        logic signed [31:0] v;
        logic [5:0] sz;
        for (int k = 0; k < n_cmds; k++)
        begin
            if (k == n_cmds - 40)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if      (pick < 15) c = CMD_CREATE;
            else if (pick < 45) c = CMD_APPEND;
            else if (pick < 52) c = CMD_DEL_LAST;
            else if (pick < 62) c = CMD_DEL_VALUE;
            else if (pick < 70) c = CMD_READ;
            else if (pick < 76) c = CMD_READ_SORT;
            else if (pick < 78) c = CMD_READ_ALL;
            else if (pick < 80) c = CMD_ALL_SORT;
            else if (pick < 87) c = CMD_GROW;
            else if (pick < 94) c = CMD_COUNT;
            else if (pick < 96) c = CMD_RELEASE;
            else                c = 4'($urandom_range(11, 15));
            s  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            // a small value pool makes delete by value hit often
            v  = $urandom_range(0, 1) ? $signed($urandom_range(0, 3)) - 2 : $urandom;
            sz = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 4));
            send_command(c, s, v, sz);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        cmd          = '0;
        slot         = '0;
        value        = '0;
        size         = '0;
        quiet        = 1'b0;
        pop_hold     = 0;
        mismatches   = 0;
        cmds_sent    = 0;
        results_seen = 0;
        reads_seen   = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_cap[i] = 0;
            shadow_cnt[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_create_checks();
        test_list_edits();
        test_grow_and_limits();
        test_release_and_unused();
        test_random_traffic(178);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d commands, checked %0d results (%0d listed words)",
                 cmds_sent, results_seen, reads_seen);
        $display("covered create/append/delete/grow/count/read/release and unused codes");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### multi_list_store_engine_unit.f
rtl/mlse_pkg.sv
rtl/mlse_front.sv
rtl/mlse_resq.sv
rtl/mlse_back.sv
rtl/multi_list_store_engine_unit.sv
dv/tb.sv
